// ===== hdl/tme_pkg.sv =====
// tme_pkg: shared types and constants of the trimmed mean engine
// used by tme_ctrl, tme_datapath, trimmed_mean_engine, tme_checker and tb_top; no dependencies
package tme_pkg;

   localparam int DefaultMaxValues = 1024;
   localparam int FracWidth        = 17;
   localparam logic [FracWidth-1:0] FRAC_ONE = 17'd65536;
   localparam logic [FracWidth-1:0] FRAC_MAX_RESET = 17'd65536;

   localparam logic REG_MIN_FRACTION = 1'b0;
   localparam logic REG_MAX_FRACTION = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREV_RD,
      ST_CMP,
      ST_PLACE,
      ST_RANK_MUL,
      ST_RANK_SET,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_prev;
      logic shift;
      logic place;
      logic rank_mul;
      logic rank_set;
      logic sum_rd;
      logic sum_acc;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last;
      logic gt;
      logic pos_one;
      logic sel_bad;
      logic sum_end;
      logic div_end;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/tme_ctrl.sv =====
// tme_ctrl: sequencer for insertion, rank, sum, divide and result phases
// depends on tme_pkg
module tme_ctrl
   import tme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.full) begin
                  state_in = status.last ? ST_RANK_MUL : ST_IDLE;
               end else if (status.empty) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_PREV_RD;
               end
            end
         end
         ST_PREV_RD: state_in = ST_CMP;
         ST_CMP: begin
            if (status.gt && !status.pos_one) begin
               state_in = ST_PREV_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:    state_in = status.last ? ST_RANK_MUL : ST_IDLE;
         ST_RANK_MUL: state_in = ST_RANK_SET;
         ST_RANK_SET: state_in = status.sel_bad ? ST_OUTPUT : ST_SUM_RD;
         ST_SUM_RD:   state_in = ST_SUM_ACC;
         ST_SUM_ACC:  state_in = status.sum_end ? ST_DIV_INIT : ST_SUM_RD;
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: state_in = status.div_end ? ST_OUTPUT : ST_DIV_STEP;
         ST_OUTPUT:   state_in = status.out_free ? ST_IDLE : ST_OUTPUT;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_PREV_RD:  cmd.rd_prev  = 1'b1;
         ST_CMP:      cmd.shift    = status.gt;
         ST_PLACE:    cmd.place    = 1'b1;
         ST_RANK_MUL: cmd.rank_mul = 1'b1;
         ST_RANK_SET: cmd.rank_set = 1'b1;
         ST_SUM_RD:   cmd.sum_rd   = 1'b1;
         ST_SUM_ACC:  cmd.sum_acc  = 1'b1;
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV_STEP: cmd.div_step = 1'b1;
         ST_OUTPUT:   cmd.finish   = status.out_free;
         default:     cmd          = '0;
      endcase
   end

endmodule

// ===== hdl/tme_datapath.sv =====
// tme_datapath: sorted store, counters, rank multiply, sum and restoring divider
// depends on tme_pkg; driven by tme_ctrl commands
module tme_datapath
   import tme_pkg::*;
#(
   parameter int MAX_VALUES = DefaultMaxValues
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic signed [31:0]   req_sample_value,
   input  logic                 req_last_sample,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [FracWidth-1:0] csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_trimmed_mean,
   output logic [1:0]           rsp_result_status
);

   localparam int CW  = $clog2(MAX_VALUES + 1);
   localparam int AW  = $clog2(MAX_VALUES);
   localparam int PW  = FracWidth + CW;
   localparam int SW  = 32 + CW;
   localparam int RW  = CW + 1;
   localparam int DCW = $clog2(SW + 1);

   logic signed [31:0] mem [MAX_VALUES];
   logic signed [31:0] rdata_ff;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_data;

   logic [FracWidth-1:0] fmin_ff, fmax_ff;
   logic [CW-1:0]        count_ff;
   logic                 ovf_ff;
   logic [AW-1:0]        pos_ff;
   logic signed [31:0]   val_ff;
   logic                 last_ff;
   logic [PW-1:0]        pmin_ff, pmax_ff;
   logic [CW-1:0]        lo_ff;
   logic [AW-1:0]        hi_ff, idx_ff;
   logic [1:0]           code_ff;
   logic signed [SW-1:0] acc_ff;
   logic [SW-1:0]        quo_ff;
   logic [RW-1:0]        rem_ff;
   logic [CW-1:0]        div_ff;
   logic                 neg_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic                 rsp_valid_ff;
   logic signed [31:0]   mean_ff;
   logic [1:0]           stat_ff;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rd_en   = cmd.rd_prev | cmd.sum_rd;
   assign rd_addr = cmd.sum_rd ? idx_ff : pos_ff - AW'(1);
   assign wr_en   = cmd.shift | cmd.place;
   assign wr_addr = pos_ff;
   assign wr_data = cmd.shift ? rdata_ff : val_ff;

   // clamped fractions and rank arithmetic
   logic [FracWidth-1:0] fmin_c, fmax_c;
   logic [PW:0]          hi_sum;
   logic [CW-1:0]        lo_c, hi_raw, n_m1, hi_c;
   logic                 bad_sel;

   assign fmin_c  = (fmin_ff > FRAC_ONE) ? FRAC_ONE : fmin_ff;
   assign fmax_c  = (fmax_ff > FRAC_ONE) ? FRAC_ONE : fmax_ff;
   assign hi_sum  = {1'b0, pmax_ff} + (PW+1)'(16'hFFFF);
   assign lo_c    = pmin_ff[16 +: CW];
   assign hi_raw  = hi_sum[16 +: CW];
   assign n_m1    = count_ff - CW'(1);
   assign hi_c    = (hi_raw > n_m1) ? n_m1 : hi_raw;
   assign bad_sel = (count_ff == '0) || (lo_c > hi_c);

   // restoring divider step
   logic [RW-1:0] rem_t, rem_sub;
   logic          rem_ge;
   assign rem_t   = {rem_ff[RW-2:0], quo_ff[SW-1]};
   assign rem_ge  = rem_t >= {1'b0, div_ff};
   assign rem_sub = rem_t - {1'b0, div_ff};

   logic [31:0] mag_low;
   assign mag_low = quo_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fmin_ff      <= '0;
         fmax_ff      <= FRAC_MAX_RESET;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_MIN_FRACTION: fmin_ff <= csr_write_data;
               REG_MAX_FRACTION: fmax_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.accept && count_ff == CW'(MAX_VALUES)) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.finish) begin
            count_ff     <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff  <= count_ff[AW-1:0];
         val_ff  <= req_sample_value;
         last_ff <= req_last_sample;
      end
      if (cmd.shift) begin
         pos_ff <= pos_ff - AW'(1);
      end
      if (cmd.rank_mul) begin
         pmin_ff <= PW'(fmin_c) * PW'(count_ff);
         pmax_ff <= PW'(fmax_c) * PW'(count_ff);
      end
      if (cmd.rank_set) begin
         lo_ff   <= lo_c;
         hi_ff   <= hi_c[AW-1:0];
         idx_ff  <= lo_c[AW-1:0];
         acc_ff  <= '0;
         code_ff <= bad_sel ? STATUS_EMPTY : (ovf_ff ? STATUS_DROPPED : STATUS_OK);
      end
      if (cmd.sum_acc) begin
         acc_ff <= acc_ff + {{CW{rdata_ff[31]}}, rdata_ff};
         idx_ff <= idx_ff + AW'(1);
      end
      if (cmd.div_init) begin
         neg_ff  <= acc_ff[SW-1];
         quo_ff  <= acc_ff[SW-1] ? SW'(-acc_ff) : SW'(acc_ff);
         rem_ff  <= '0;
         div_ff  <= CW'({1'b0, hi_ff}) - lo_ff + CW'(1);
         dcnt_ff <= DCW'(SW);
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_sub : rem_t;
         quo_ff  <= {quo_ff[SW-2:0], rem_ge};
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
      if (cmd.finish) begin
         stat_ff <= code_ff;
         mean_ff <= (code_ff != STATUS_OK) ? 32'sd0 :
                    (neg_ff ? $signed(-mag_low) : $signed(mag_low));
      end
   end

   assign status.full     = count_ff == CW'(MAX_VALUES);
   assign status.empty    = count_ff == '0;
   assign status.last     = cmd.accept ? req_last_sample : last_ff;
   assign status.gt       = rdata_ff > val_ff;
   assign status.pos_one  = pos_ff == AW'(1);
   assign status.sel_bad  = bad_sel || ovf_ff;
   assign status.sum_end  = idx_ff == hi_ff;
   assign status.div_end  = dcnt_ff == DCW'(1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trimmed_mean  = mean_ff;
   assign rsp_result_status = stat_ff;

endmodule

// ===== hdl/trimmed_mean_engine.sv =====
// trimmed_mean_engine: top level, joins the sequencer and the datapath
// depends on tme_pkg, tme_ctrl and tme_datapath

// takes a set of signed q16.16 values one item at a time and keeps them in
// ascending order in an internal memory by insertion; the item flagged last
// closes the set and gives one result item with the trimmed mean and a status
// (0 ok, 1 empty selection, 2 values dropped for capacity). an inserted item
// goes straight to its place in an empty store; else the held values are read
// from the top down through the single read port of the sorted store, and each
// one larger than the item is shifted up one place before the item is placed.
// a dropped item is only taken in. closing a set runs the rank steps, then for
// a good selection the sum over the selected values and the restoring divide,
// and the output step plus any result stall. items beyond MAX_VALUES are dropped.
// the fraction registers must be written only while idle, by the user; the
// block itself does not enforce this. values above 1.0 act as 1.0
module trimmed_mean_engine
   import tme_pkg::*;
#(
   parameter int MAX_VALUES = DefaultMaxValues
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_sample_value,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_trimmed_mean,
   output logic [1:0]           rsp_result_status,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [FracWidth-1:0] csr_write_data
);

   // command and status groups between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   tme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tme_datapath #(
      .MAX_VALUES (MAX_VALUES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample_value  (req_sample_value),
      .req_last_sample   (req_last_sample),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trimmed_mean  (rsp_trimmed_mean),
      .rsp_result_status (rsp_result_status)
   );

   // a faulted result always carries a zero mean
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_status != STATUS_OK) |-> rsp_trimmed_mean == 32'sd0)
      else $error("faulted result with nonzero mean");

   // status code never takes the unused value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_status == STATUS_OK || rsp_result_status == STATUS_EMPTY ||
                     rsp_result_status == STATUS_DROPPED))
      else $error("unused status code");

endmodule

// ===== bench/tme_checker.sv =====
// tme_checker: watches the item and result channels of trimmed_mean_engine,
// predicts each result item and compares it; depends on tme_pkg only
module tme_checker
   import tme_pkg::*;
#(
   parameter int MAX_VALUES = DefaultMaxValues
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [31:0]   req_sample_value,
   input  logic                 req_last_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [31:0]   rsp_trimmed_mean,
   input  logic [1:0]           rsp_result_status,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [FracWidth-1:0] csr_write_data,
   output int                   fail_count,
   output int                   pending_results
);

   typedef struct {
      logic signed [31:0] mean;
      logic [1:0]         status;
   } mean_result_type;

   logic signed [31:0]   held_values[$];
   logic                 dropped_seen;
   logic [FracWidth-1:0] min_frac;
   logic [FracWidth-1:0] max_frac;
   mean_result_type      expected_means[$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   function automatic void store_value(logic signed [31:0] v);
      int pos;
      if (held_values.size() >= MAX_VALUES) begin
         dropped_seen = 1'b1;
         return;
      end
      pos = held_values.size();
      while (pos > 0 && held_values[pos-1] > v) pos--;
      held_values.insert(pos, v);
   endfunction

   function automatic mean_result_type trimmed_mean_of_set();
      mean_result_type r;
      longint          n, lo, hi, fmin, fmax, total;
      n    = held_values.size();
      fmin = (min_frac > FRAC_ONE) ? FRAC_ONE : min_frac;
      fmax = (max_frac > FRAC_ONE) ? FRAC_ONE : max_frac;
      r.mean   = '0;
      r.status = STATUS_OK;
      if (n == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         lo = (fmin * n) >>> 16;
         hi = (fmax * n + 65535) >>> 16;
         if (hi > n - 1) hi = n - 1;
         if (lo > hi) begin
            r.status = STATUS_EMPTY;
         end else if (dropped_seen) begin
            r.status = STATUS_DROPPED;
         end else begin
            total = 0;
            for (longint i = lo; i <= hi; i++) total += held_values[i];
            r.mean = 32'(total / (hi - lo + 1));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      mean_result_type want;
      if (reset) begin
         held_values.delete();
         expected_means.delete();
         dropped_seen = 1'b0;
         min_frac     = '0;
         max_frac     = FRAC_MAX_RESET;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_MIN_FRACTION) min_frac = csr_write_data;
            else max_frac = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            store_value(req_sample_value);
            if (req_last_sample) begin
               expected_means.insert(expected_means.size(), trimmed_mean_of_set());
               held_values.delete();
               dropped_seen = 1'b0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_means.size() == 0) begin
               $display("%0t: unexpected result mean %0d status %0d", $time,
                        rsp_trimmed_mean, rsp_result_status);
               fail_count++;
            end else begin
               want = expected_means.pop_front();
               if (rsp_trimmed_mean !== want.mean) begin
                  $display("%0t: trimmed_mean expected %0d actual %0d", $time,
                           want.mean, rsp_trimmed_mean);
                  fail_count++;
               end
               if (rsp_result_status !== want.status) begin
                  $display("%0t: result_status expected %0d actual %0d", $time,
                           want.status, rsp_result_status);
                  fail_count++;
               end
            end
         end
      end
      pending_results = expected_means.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: drives sets of samples and trim settings into trimmed_mean_engine
// and gives the verdict; depends on tme_pkg, trimmed_mean_engine, tme_checker
module tb_top;
   import tme_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int MAX_VALUES = DefaultMaxValues;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [31:0]   req_sample_value;
   logic                 req_last_sample;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [31:0]   rsp_trimmed_mean;
   logic [1:0]           rsp_result_status;
   logic                 csr_write_enable;
   logic                 csr_index;
   logic [FracWidth-1:0] csr_write_data;

   int fail_count;
   int pending_results;
   int idle_cycles;
   bit calm;        // no idling on either side in the last part
   bit long_hold;   // asks the result side for one long hold-off

   trimmed_mean_engine dut (.*);

   tme_checker u_checker (.*);

   always #10 clock = ~clock;

   // watchdog: cycles in which no item and no result is accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("[trimmed_mean_engine] ERROR");
            $finish;
         end
      end
   end

   // result side stall, random bursts plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one item and hold it until accepted, optional gap before it
   task automatic send_item(input logic [31:0] v, input logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= v;
      req_last_sample  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // wait until every result item is in and the block has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [FracWidth-1:0] d);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= d;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_trim(input logic [FracWidth-1:0] lo, input logic [FracWidth-1:0] hi);
      drain();
      csr_write(REG_MIN_FRACTION, lo);
      csr_write(REG_MAX_FRACTION, hi);
   endtask

   // one set with random content; narrow values give many ties
   task automatic send_random_set(input int n);
      bit narrow;
      narrow = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++)
         send_item(narrow ? 32'($urandom_range(0, 7)) - 32'd4 : $urandom, i == n - 1);
   endtask

   // ascending set that fills the store and then drops the extra items
   task automatic send_overflow_set(input int n);
      longint v;
      for (int i = 0; i < n; i++) begin
         v = longint'(i) * 4000000 - 64'sd2147483648;
         send_item(32'(v), i == n - 1);
      end
   endtask

   task automatic random_phase(input int items, input bit with_hold);
      int sent;
      int n;
      bit hold_done;
      sent      = 0;
      hold_done = 1'b0;
      while (sent < items) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         if (with_hold && !hold_done && sent >= items / 3) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         send_random_set(n);
         sent += n;
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      req_last_sample  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = REG_MIN_FRACTION;
      csr_write_data   = '0;
      calm             = 1'b0;
      long_hold        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes with the full range selected
      set_trim(17'd0, FRAC_ONE);
      send_item(32'h7fffffff, 1'b1);
      send_item(32'h80000000, 1'b1);
      send_item(32'h7fffffff, 1'b0);
      send_item(32'h7fffffff, 1'b0);
      send_item(32'h7fffffff, 1'b1);   // sum wider than 32 bits
      send_item(32'h80000000, 1'b0);
      send_item(32'h80000000, 1'b1);
      send_item(32'hffffffff, 1'b0);   // negative mean truncates toward zero
      send_item(32'hfffffffe, 1'b1);
      send_item(32'd5, 1'b0);          // ties and reverse order
      send_item(32'd5, 1'b0);
      send_item(32'd3, 1'b0);
      send_item(32'd9, 1'b1);
      // empty selection: lower trim at 1.0
      set_trim(FRAC_ONE, FRAC_ONE);
      send_item(32'd7, 1'b0);
      send_item(32'd1, 1'b1);
      // registers above 1.0 clamp
      set_trim(17'h1ffff, 17'h1ffff);
      send_item(32'd2, 1'b1);
      set_trim(17'd0, 17'd0);
      send_item(32'd4, 1'b0);
      send_item(32'd8, 1'b0);
      send_item(32'hfff00000, 1'b1);
      set_trim(17'd16384, 17'd49152);
      send_item(32'd10, 1'b0);
      send_item(32'd40, 1'b0);
      send_item(32'd20, 1'b0);
      send_item(32'd30, 1'b1);

      // full store: dropped items, closing item dropped too
      set_trim(17'd0, FRAC_ONE);
      send_overflow_set(MAX_VALUES + 1);

      // random sets under several trim settings, sender paused between them
      set_trim(17'd6553, 17'd58982);
      random_phase(200, 1'b1);
      set_trim(17'd32768, 17'h1ffff);
      random_phase(150, 1'b0);
      set_trim(17'd0, 17'd0);
      random_phase(100, 1'b0);
      set_trim(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 131071)));
      random_phase(150, 1'b0);
      set_trim(17'($urandom_range(0, 32768)), 17'($urandom_range(32768, 65536)));
      random_phase(150, 1'b0);
      set_trim(17'd0, FRAC_ONE);
      calm = 1'b1;
      random_phase(100, 1'b0);

      drain();
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("[trimmed_mean_engine] OK");
      end else begin
         $display("[trimmed_mean_engine] ERROR");
      end
      $finish;
   end

endmodule
